@@ rtl/e2dc2p_pkg.sv @@
// Package for the 2D Euler conservative-to-primitive converter.
// Holds register indexes, reset values, status codes and the saturation helper.
// No dependencies.
package e2dc2p_pkg;

	// default number of fraction bits of all fixed-point values
	localparam int FRAC_BITS_DEF = 16;

	// configuration register indexes
	localparam logic [1:0] REG_GAMMA  = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_GAS    = 2'd2;

	// register widths and reset values
	localparam int GAMMA_W  = 19;
	localparam int OFFSET_W = 31;
	localparam int GAS_W    = 31;
	localparam logic [GAMMA_W-1:0]  GAMMA_RESET  = 19'd91750;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 31'd0;
	localparam logic [GAS_W-1:0]    GAS_RESET    = 31'd18808832;

	// result status codes
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_BAD_DENSITY = 2'd1;
	localparam logic [1:0] STATUS_SATURATED   = 2'd2;

	// Signed 32-bit value from sign and magnitude, clamped to the 32-bit range.
	// Returns {saturated, value}.
	function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
		logic        over;
		logic [31:0] val;
		begin
			if (neg) begin
				over = mag > 64'h0000_0000_8000_0000;
				val  = over ? 32'h8000_0000 : (32'd0 - mag[31:0]);
			end else begin
				over = mag > 64'h0000_0000_7FFF_FFFF;
				val  = over ? 32'h7FFF_FFFF : mag[31:0];
			end
			sat_mag = {over, val};
		end
	endfunction

endpackage

@@ rtl/euler2d_conservative_to_primitive.sv @@
// Top level of the 2D Euler conservative-to-primitive converter.
// Depends on e2dc2p_pkg; all work is done in one deep pipeline in this module.
//
//  channel   signals                                             direction
//  input     in_valid/in_ready, density, momentum_x/_y,          request in
//            energy_density
//  output    out_valid/out_ready, gauge_pressure, velocity_x/_y, result out
//            temperature, status
//  config    cfg_write, cfg_index, cfg_data                      write only
//
// One request enters every cycle unless an untaken result holds the output.
// The depth is set by the bit-per-stage dividers: 64 steps for the kinetic
// term and 32 steps for the temperature quotient, run one after the other.
// Reset only clears the valid bits and loads the configuration reset values.
// When the output holds an untaken result, every stage freezes together.
module euler2d_conservative_to_primitive #(
	parameter int FRAC_BITS = e2dc2p_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] density,
	input  logic [31:0] momentum_x,
	input  logic [31:0] momentum_y,
	input  logic [31:0] energy_density,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] gauge_pressure,
	output logic [31:0] velocity_x,
	output logic [31:0] velocity_y,
	output logic [31:0] temperature,
	output logic [1:0]  status,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	// stage map
	localparam int UV_N    = 32;
	localparam int K_N     = 64;
	localparam int T_N     = 32;
	localparam int ST_SQ   = 1;
	localparam int ST_UV0  = 2;
	localparam int ST_K0   = 3;
	localparam int ST_DIFF = ST_K0 + K_N;
	localparam int ST_MUL  = ST_DIFF + 1;
	localparam int ST_PT   = ST_MUL + 1;
	localparam int ST_GD   = ST_PT + 1;
	localparam int ST_TS   = ST_GD + 1;
	localparam int ST_T0   = ST_TS + 1;
	localparam int ST_OUT  = ST_T0 + T_N;
	localparam int NSTAGE  = ST_OUT + 1;

	typedef struct packed {
		logic               ok;
		logic [30:0]        rho;
		logic signed [31:0] re;
		logic               mx_neg;
		logic               my_neg;
		logic [31:0]        mxm;
		logic [31:0]        mym;
		logic [63:0]        sqx;
		logic [63:0]        sqy;
		logic [31:0]        u_r;
		logic [31:0]        u_n;
		logic [31:0]        u_q;
		logic               u_ovf;
		logic [31:0]        v_r;
		logic [31:0]        v_n;
		logic [31:0]        v_q;
		logic               v_ovf;
		logic [31:0]        k_r;
		logic [63:0]        k_n;
		logic [63:0]        k_q;
		logic [63:0]        d;
		logic               neg;
		logic [62:0]        plo;
		logic [62:0]        phi;
		logic signed [31:0] ptot;
		logic               sat;
		logic [31:0]        gauge;
		logic [61:0]        den;
		logic [61:0]        t_r;
		logic [31:0]        t_n;
		logic [31:0]        t_q;
		logic               t_ovf;
		logic [31:0]        vx;
		logic [31:0]        vy;
		logic [31:0]        tp;
		logic [1:0]         st;
	} item_t;

	// configuration registers
	logic [e2dc2p_pkg::GAMMA_W-1:0]  gamma_q;
	logic [e2dc2p_pkg::OFFSET_W-1:0] offset_q;
	logic [e2dc2p_pkg::GAS_W-1:0]    gas_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q  <= e2dc2p_pkg::GAMMA_RESET;
			offset_q <= e2dc2p_pkg::OFFSET_RESET;
			gas_q    <= e2dc2p_pkg::GAS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				e2dc2p_pkg::REG_GAMMA:  gamma_q  <= cfg_data[e2dc2p_pkg::GAMMA_W-1:0];
				e2dc2p_pkg::REG_OFFSET: offset_q <= cfg_data[e2dc2p_pkg::OFFSET_W-1:0];
				e2dc2p_pkg::REG_GAS:    gas_q    <= cfg_data[e2dc2p_pkg::GAS_W-1:0];
				default: ;
			endcase
		end
	end

	// gamma - 1 as sign and magnitude
	logic signed [31:0] gm1;
	logic [30:0]        gmag;
	assign gm1  = $signed(32'(gamma_q)) - $signed(32'd1 << FRAC_BITS);
	assign gmag = gm1[31] ? 31'(32'd0 - gm1) : gm1[30:0];

	// pipeline
	logic  vld_s  [NSTAGE];
	item_t item_s [NSTAGE];
	logic  en;

	assign en       = !vld_s[NSTAGE-1] || out_ready;
	assign in_ready = en;

	// input stage: register request, take magnitudes
	item_t in_item;
	always_comb begin
		in_item        = item_s[0];
		in_item.ok     = $signed(density) > 32'sd0;
		in_item.rho    = density[30:0];
		in_item.re     = $signed(energy_density);
		in_item.mx_neg = momentum_x[31];
		in_item.my_neg = momentum_y[31];
		in_item.mxm    = momentum_x[31] ? 32'd0 - momentum_x : momentum_x;
		in_item.mym    = momentum_y[31] ? 32'd0 - momentum_y : momentum_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= in_item;
		end
	end

	for (genvar i = 1; i < NSTAGE; i++) begin : g_stage
		item_t nxt;

		always_comb begin
			logic [32+FRAC_BITS-1:0]   nu;
			logic [32+FRAC_BITS-1:0]   nv;
			logic [32:0]               r33;
			logic [32:0]               rk;
			logic signed [64:0]        df;
			logic [63:0]               pm;
			logic [32:0]               cl;
			logic signed [32:0]        g33;
			logic [31:0]               ptm;
			logic [32+2*FRAC_BITS-1:0] nt;
			logic [62:0]               rt;
			nu  = '0;
			nv  = '0;
			r33 = '0;
			rk  = '0;
			df  = '0;
			pm  = '0;
			cl  = '0;
			g33 = '0;
			ptm = '0;
			nt  = '0;
			rt  = '0;
			nxt = item_s[i-1];

			// squares and velocity divider setup
			if (i == ST_SQ) begin
				nxt.sqx   = 64'(item_s[i-1].mxm) * 64'(item_s[i-1].mxm);
				nxt.sqy   = 64'(item_s[i-1].mym) * 64'(item_s[i-1].mym);
				nu        = {item_s[i-1].mxm, FRAC_BITS'(0)};
				nv        = {item_s[i-1].mym, FRAC_BITS'(0)};
				nxt.u_r   = 32'(nu[32+FRAC_BITS-1:32]);
				nxt.u_n   = nu[31:0];
				nxt.u_q   = '0;
				nxt.u_ovf = 32'(nu[32+FRAC_BITS-1:32]) >= 32'(item_s[i-1].rho);
				nxt.v_r   = 32'(nv[32+FRAC_BITS-1:32]);
				nxt.v_n   = nv[31:0];
				nxt.v_q   = '0;
				nxt.v_ovf = 32'(nv[32+FRAC_BITS-1:32]) >= 32'(item_s[i-1].rho);
			end

			// kinetic divider setup: sum of squares over 2 rho
			if (i == ST_UV0) begin
				nxt.k_r = '0;
				nxt.k_n = item_s[i-1].sqx + item_s[i-1].sqy;
				nxt.k_q = '0;
			end

			// velocity divider steps, one quotient bit each
			if (i >= ST_UV0 && i < ST_UV0 + UV_N) begin
				r33 = {item_s[i-1].u_r, item_s[i-1].u_n[31]};
				if (r33 >= 33'(item_s[i-1].rho)) begin
					r33 = r33 - 33'(item_s[i-1].rho);
					nxt.u_q = {item_s[i-1].u_q[30:0], 1'b1};
				end else begin
					nxt.u_q = {item_s[i-1].u_q[30:0], 1'b0};
				end
				nxt.u_r = r33[31:0];
				nxt.u_n = {item_s[i-1].u_n[30:0], 1'b0};

				r33 = {item_s[i-1].v_r, item_s[i-1].v_n[31]};
				if (r33 >= 33'(item_s[i-1].rho)) begin
					r33 = r33 - 33'(item_s[i-1].rho);
					nxt.v_q = {item_s[i-1].v_q[30:0], 1'b1};
				end else begin
					nxt.v_q = {item_s[i-1].v_q[30:0], 1'b0};
				end
				nxt.v_r = r33[31:0];
				nxt.v_n = {item_s[i-1].v_n[30:0], 1'b0};
			end

			// kinetic divider steps, divisor 2 rho
			if (i >= ST_K0 && i < ST_K0 + K_N) begin
				rk = {item_s[i-1].k_r, item_s[i-1].k_n[63]};
				if (rk >= {1'b0, item_s[i-1].rho, 1'b0}) begin
					rk = rk - {1'b0, item_s[i-1].rho, 1'b0};
					nxt.k_q = {item_s[i-1].k_q[62:0], 1'b1};
				end else begin
					nxt.k_q = {item_s[i-1].k_q[62:0], 1'b0};
				end
				nxt.k_r = rk[31:0];
				nxt.k_n = {item_s[i-1].k_n[62:0], 1'b0};
			end

			// internal energy: rhoE - K as sign and magnitude
			if (i == ST_DIFF) begin
				df      = 65'(item_s[i-1].re) - $signed({1'b0, item_s[i-1].k_q});
				nxt.d   = df[64] ? 64'(65'sd0 - df) : df[63:0];
				nxt.neg = df[64] != gm1[31];
			end

			// scale by gamma - 1, two 32-bit halves
			if (i == ST_MUL) begin
				nxt.plo = 63'(item_s[i-1].d[31:0]) * 63'(gmag);
				nxt.phi = 63'(item_s[i-1].d[63:32]) * 63'(gmag);
			end

			// total pressure, saturated
			if (i == ST_PT) begin
				if (item_s[i-1].phi >= (63'd1 << FRAC_BITS)) begin
					pm = 64'd1 << 32;
				end else begin
					pm = (64'(item_s[i-1].phi) << (32 - FRAC_BITS))
						+ 64'(item_s[i-1].plo >> FRAC_BITS);
				end
				cl       = e2dc2p_pkg::sat_mag(item_s[i-1].neg, pm);
				nxt.ptot = $signed(cl[31:0]);
				nxt.sat  = cl[32];
			end

			// gauge pressure and R * rho
			if (i == ST_GD) begin
				g33 = 33'(item_s[i-1].ptot) - $signed({2'b00, offset_q});
				if (g33[32] != g33[31]) begin
					nxt.gauge = 32'h8000_0000;
					nxt.sat   = 1'b1;
				end else begin
					nxt.gauge = g33[31:0];
				end
				nxt.den = 62'(gas_q) * 62'(item_s[i-1].rho);
			end

			// temperature divider setup
			if (i == ST_TS) begin
				ptm       = item_s[i-1].ptot[31] ? 32'd0 - item_s[i-1].ptot
					: item_s[i-1].ptot;
				nt        = {ptm, (2*FRAC_BITS)'(0)};
				nxt.t_r   = 62'(nt[32+2*FRAC_BITS-1:32]);
				nxt.t_n   = nt[31:0];
				nxt.t_q   = '0;
				nxt.t_ovf = 64'(nt[32+2*FRAC_BITS-1:32]) >= 64'(item_s[i-1].den);
			end

			// temperature divider steps
			if (i >= ST_T0 && i < ST_T0 + T_N) begin
				rt = {item_s[i-1].t_r, item_s[i-1].t_n[31]};
				if (rt >= 63'(item_s[i-1].den)) begin
					rt = rt - 63'(item_s[i-1].den);
					nxt.t_q = {item_s[i-1].t_q[30:0], 1'b1};
				end else begin
					nxt.t_q = {item_s[i-1].t_q[30:0], 1'b0};
				end
				nxt.t_r = rt[61:0];
				nxt.t_n = {item_s[i-1].t_n[30:0], 1'b0};
			end

			// clamp quotients, pick status
			if (i == ST_OUT) begin
				cl = e2dc2p_pkg::sat_mag(item_s[i-1].mx_neg,
					{31'd0, item_s[i-1].u_ovf, item_s[i-1].u_q});
				nxt.vx  = cl[31:0];
				nxt.sat = item_s[i-1].sat | cl[32];
				cl = e2dc2p_pkg::sat_mag(item_s[i-1].my_neg,
					{31'd0, item_s[i-1].v_ovf, item_s[i-1].v_q});
				nxt.vy  = cl[31:0];
				nxt.sat = nxt.sat | cl[32];
				if (gas_q == '0) begin
					nxt.tp  = '0;
					nxt.sat = 1'b1;
				end else begin
					cl = e2dc2p_pkg::sat_mag(item_s[i-1].ptot[31],
						{31'd0, item_s[i-1].t_ovf, item_s[i-1].t_q});
					nxt.tp  = cl[31:0];
					nxt.sat = nxt.sat | cl[32];
				end
				if (!item_s[i-1].ok) begin
					nxt.gauge = '0;
					nxt.vx    = '0;
					nxt.vy    = '0;
					nxt.tp    = '0;
					nxt.st    = e2dc2p_pkg::STATUS_BAD_DENSITY;
				end else if (nxt.sat) begin
					nxt.st = e2dc2p_pkg::STATUS_SATURATED;
				end else begin
					nxt.st = e2dc2p_pkg::STATUS_OK;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[i] <= nxt;
			end
		end
	end

	// result port
	assign out_valid      = vld_s[NSTAGE-1];
	assign gauge_pressure = item_s[NSTAGE-1].gauge;
	assign velocity_x     = item_s[NSTAGE-1].vx;
	assign velocity_y     = item_s[NSTAGE-1].vy;
	assign temperature    = item_s[NSTAGE-1].tp;
	assign status         = item_s[NSTAGE-1].st;

endmodule
